// File: sv/ttss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttss_pkg
// Shared types, constants and helpers of the timed task slot scheduler.
// ----------------------------------------------------------------------------
package ttss_pkg;

	localparam int MAX_SLOTS   = 32;
	localparam int FIELD_SLOTS = 32;
	localparam int LIM_SLOTS   = (MAX_SLOTS < FIELD_SLOTS) ? MAX_SLOTS : FIELD_SLOTS;
	localparam int SLOT_W      = 5;
	localparam int CNT_W       = 6;
	localparam int SLEEP_W     = 31;
	localparam int TIME_W      = 32;

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_CREATE  = 3'd1;
	localparam logic [2:0] OP_DELETE  = 3'd2;
	localparam logic [2:0] OP_RESUME  = 3'd3;
	localparam logic [2:0] OP_SUSPEND = 3'd4;
	localparam logic [2:0] OP_SETWAIT = 3'd5;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

	typedef struct packed {
		logic [2:0]         opcode;
		logic [SLOT_W-1:0]  slot;
		logic [TIME_W-1:0]  now_ms;
		logic [SLEEP_W-1:0] wait_ms;
	} in_t;

	typedef struct packed {
		logic [SLOT_W-1:0] ready_slot;
		logic              ready_valid;
		logic              last;
	} out_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (c == '0) r = CNT_W'(2);
		if (r > CNT_W'(LIM_SLOTS)) r = CNT_W'(LIM_SLOTS);
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] lowest(input logic [MAX_SLOTS-1:0] v);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			if (v[i]) r = SLOT_W'(i);
		end
		return r;
	endfunction

endpackage

// File: sv/ttss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttss_front
// Accepts commands, drops bad opcodes, slots and zero waits, queues the rest.
// ----------------------------------------------------------------------------
module ttss_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  ttss_pkg::in_t             cmd,
	input  logic [ttss_pkg::CNT_W-1:0] count,
	output logic                      q_valid,
	output ttss_pkg::in_t             q_data,
	input  logic                      q_pop
);
	import ttss_pkg::*;

	in_t        fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push;
	logic       in_range;

	assign in_range  = {1'b0, cmd.slot} < count;
	assign cmd_stall = (cnt_q == 2'd2);

	always_comb begin
		case (cmd.opcode)
			OP_TICK, OP_CREATE:              keep = 1'b1;
			OP_DELETE, OP_RESUME, OP_SUSPEND: keep = in_range;
			OP_SETWAIT:                      keep = in_range && (cmd.wait_ms != '0);
			default:                         keep = 1'b0;
		endcase
	end

	assign push    = cmd_valid && !cmd_stall && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// File: sv/ttss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttss_back
// Executes queued commands on the slot table and drives the result register.
// ----------------------------------------------------------------------------
module ttss_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ttss_pkg::CNT_W-1:0] count,
	input  logic                      q_valid,
	input  ttss_pkg::in_t             q_data,
	output logic                      q_pop,
	output logic                      res_valid,
	input  logic                      res_stall,
	output ttss_pkg::out_t            res
);
	import ttss_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]           state_q;
	logic [MAX_SLOTS-1:0] active_q;
	logic [MAX_SLOTS-1:0] susp_q;
	logic [SLEEP_W-1:0]   sleep_q [MAX_SLOTS];
	logic [TIME_W-1:0]    last_time_q;
	logic [TIME_W-1:0]    dt_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [MAX_SLOTS-1:0] rdy_q;
	logic                 res_valid_q;
	out_t                 res_q;

	logic                 can_load;
	logic                 load_res;
	logic [MAX_SLOTS-1:0] below;
	logic [MAX_SLOTS-1:0] free_v;
	logic [SLOT_W-1:0]    free_idx;
	logic [SLEEP_W-1:0]   cur;
	logic [SLEEP_W-1:0]   nxt;
	logic [SLOT_W-1:0]    pick;
	logic [MAX_SLOTS-1:0] rest;

	assign can_load = !res_valid_q || !res_stall;

	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) below[i] = (CNT_W'(i) < count);
	end

	assign free_v   = ~active_q & below;
	assign free_idx = lowest(free_v);
	assign cur      = sleep_q[idx_q];
	assign nxt      = ({1'b0, cur} <= dt_q) ? '0 : SLEEP_W'({1'b0, cur} - dt_q);
	assign pick     = lowest(rdy_q);
	assign rest     = rdy_q & ~(MAX_SLOTS'(1) << pick);
	assign q_pop    = (state_q == S_IDLE) && q_valid &&
	                  (q_data.opcode != OP_CREATE || can_load);
	assign load_res = (q_pop && q_data.opcode == OP_CREATE) ||
	                  (state_q == S_EMIT && can_load);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (q_pop && q_data.opcode == OP_CREATE && free_v != '0)
			sleep_q[free_idx] <= '0;
		else if (q_pop && q_data.opcode == OP_RESUME && active_q[q_data.slot])
			sleep_q[q_data.slot] <= '0;
		else if (q_pop && q_data.opcode == OP_SETWAIT && active_q[q_data.slot])
			sleep_q[q_data.slot] <= q_data.wait_ms;
		else if (state_q == S_WALK && active_q[idx_q] && !susp_q[idx_q])
			sleep_q[idx_q] <= nxt;
		if (q_pop && q_data.opcode == OP_TICK) dt_q <= q_data.now_ms - last_time_q;
		if (can_load) begin
			if (q_pop && q_data.opcode == OP_CREATE)
				res_q <= '{ready_slot: free_idx, ready_valid: (free_v != '0), last: 1'b1};
			else if (state_q == S_EMIT)
				res_q <= '{ready_slot: pick, ready_valid: (rdy_q != '0),
				           last: (rest == '0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= '0;
			susp_q      <= '0;
			last_time_q <= '0;
			idx_q       <= '0;
			rdy_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= load_res ? 1'b1 : (can_load ? 1'b0 : res_valid_q);
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						case (q_data.opcode)
							OP_TICK: begin
								last_time_q <= q_data.now_ms;
								idx_q       <= '0;
								rdy_q       <= '0;
								state_q     <= S_WALK;
							end
							OP_CREATE: begin
								if (free_v != '0) begin
									active_q[free_idx] <= 1'b1;
									susp_q[free_idx]   <= 1'b0;
								end
							end
							OP_DELETE: active_q[q_data.slot] <= 1'b0;
							OP_RESUME: begin
								if (active_q[q_data.slot]) susp_q[q_data.slot] <= 1'b0;
							end
							OP_SUSPEND: begin
								if (active_q[q_data.slot]) susp_q[q_data.slot] <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_WALK: begin
					if (active_q[idx_q] && !susp_q[idx_q] && nxt == '0) rdy_q[idx_q] <= 1'b1;
					idx_q <= idx_q + 1'b1;
					if ({1'b0, idx_q} == count - 1'b1) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (can_load) begin
						rdy_q <= rest;
						if (rest == '0) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/timed_task_slot_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_task_slot_scheduler
// Task slot table with millisecond sleep countdowns and ready reporting.
// ----------------------------------------------------------------------------
// A two-entry command queue takes transactions while the executor works.
// Create, delete, resume, suspend and set wait are each executed in the
// idle state. A tick records the time and starts the slot walk, visits one
// slot per cycle over the configured slot count n, then gives one result
// per cycle per ready slot while results are not stalled (or one result
// if none is ready).
// ----------------------------------------------------------------------------
module timed_task_slot_scheduler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  ttss_pkg::in_t             cmd,
	output logic                      res_valid,
	input  logic                      res_stall,
	output ttss_pkg::out_t            res,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ttss_pkg::CNT_W-1:0] cfg_data
);
	import ttss_pkg::*;

	logic [CNT_W-1:0] slot_count_q;
	logic [CNT_W-1:0] count;
	logic             q_valid;
	in_t              q_data;
	logic             q_pop;

	assign cfg_ready = 1'b1;
	assign count     = eff_count(slot_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slot_count_q <= CNT_RESET;
		else if (cfg_valid && cfg_ready) slot_count_q <= cfg_data;
	end

	ttss_front u_front (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.cmd(cmd), .count(count), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	ttss_back u_back (
		.clk(clk), .arst_n(arst_n), .count(count), .q_valid(q_valid), .q_data(q_data),
		.q_pop(q_pop), .res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

endmodule

// File: sv/ttss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttss_port_checker
// Port level checks of the timed task slot scheduler.
// ----------------------------------------------------------------------------
module ttss_port_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_stall,
	input ttss_pkg::out_t res
);
	import ttss_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res)) else $error("result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.ready_valid |-> res.last) else $error("empty result not last");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.ready_valid |-> res.ready_slot == '0)
		else $error("empty result with slot");

endmodule

bind timed_task_slot_scheduler ttss_port_checker u_ttss_port_checker (
	.clk(clk), .arst_n(arst_n), .res_valid(res_valid), .res_stall(res_stall), .res(res)
);
